@@ rtl/ucss_pkg.sv @@
// Package for the UTF-8 decoder with CSS preprocessing.
// Holds the channel word types, decoder state type and code point constants.
// No dependencies.
package ucss_pkg;

  // Code points and byte values used by the decoder
  localparam logic [20:0] CP_REPL = 21'h00FFFD;
  localparam logic [20:0] CP_BOM  = 21'h00FEFF;
  localparam logic [20:0] CP_LF   = 21'h00000A;
  localparam logic [20:0] CP_FF   = 21'h00000C;
  localparam logic [20:0] CP_CR   = 21'h00000D;
  localparam logic [20:0] CP_NUL  = 21'h000000;

  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] E0_LO    = 8'hA0;
  localparam logic [7:0] ED_HI    = 8'h9F;
  localparam logic [7:0] F0_LO    = 8'h90;
  localparam logic [7:0] F4_HI    = 8'h8F;

  // Input word: one raw byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } src_t;

  // Output word: one code point or end marker
  typedef struct packed {
    logic [20:0] code_point;
    logic        has_code;
    logic        end_of_text;
    logic        run_last;
  } res_t;

  // Up to two results produced by one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_set_t;

  // Decoder and preprocessing state
  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  needed;
    logic [1:0]  seen;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        prev_cr;
    logic        none_yet;
    logic        halted;
  } dec_state_t;

  localparam dec_state_t DEC_RESET = '{
    partial:  21'd0,
    needed:   2'd0,
    seen:     2'd0,
    lo:       CONT_LO,
    hi:       CONT_HI,
    prev_cr:  1'b0,
    none_yet: 1'b1,
    halted:   1'b0
  };

endpackage

@@ rtl/utf8_decoder_css_preprocess.sv @@
// Top level of the UTF-8 decoder with CSS preprocessing.
// Depends on ucss_pkg, ucss_decode and ucss_outbuf.
//
// Usage:
//   Input channel src_*: one raw stylesheet byte per word, with stream_end
//   on the last byte of a stream. Output channel res_*: one code point per
//   word (has_code 1), or a lone end marker (has_code 0) when the final byte
//   produced nothing; run_last flags the last word caused by a byte and
//   end_of_text the final word of the stream.
//   A byte waits in the input register, its words in the result buffer.
//   Throughput: one byte per cycle while res_* does not stall and each byte
//   gives at most one word; a byte giving two words holds the next byte back
//   until its second word is taken, since the result buffer has a single output port.
//   A stall on res_* backs up through the result buffer and the input
//   register to src_stall; nothing is dropped.
//   Reset (synchronous) empties both registers and returns the decoder to
//   the start-of-stream state, ready for a byte-order mark.
module utf8_decoder_css_preprocess (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  ucss_pkg::src_t   src_data,
  output logic             res_valid,
  input  logic             res_stall,
  output ucss_pkg::res_t   res_data
);
  import ucss_pkg::*;

  logic       iv;
  src_t       ipay;
  dec_state_t st;
  dec_state_t st_next;
  res_set_t   res_set;
  logic       can_load;
  logic       adv;

  assign adv       = iv && can_load;
  assign src_stall = iv && !can_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (src_valid && !src_stall) begin
      iv <= 1'b1;
    end else if (adv) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      ipay <= src_data;
    end
  end

  // Decoder state advances with each byte moved into the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DEC_RESET;
    end else if (adv) begin
      st <= st_next;
    end
  end

  ucss_decode u_decode (
    .st      (st),
    .src     (ipay),
    .st_next (st_next),
    .res     (res_set)
  );

  ucss_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .res       (res_set),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

@@ rtl/ucss_decode.sv @@
// Single-pass decode of one byte: UTF-8 step, preprocessing and result packing.
// Purely combinational. Depends on ucss_pkg.
module ucss_decode (
  input  ucss_pkg::dec_state_t st,
  input  ucss_pkg::src_t       src,
  output ucss_pkg::dec_state_t st_next,
  output ucss_pkg::res_set_t   res
);
  import ucss_pkg::*;

  typedef struct packed {
    logic        emit;
    logic [20:0] cp;
    logic [1:0]  need;
    logic [20:0] part;
    logic [7:0]  lo;
    logic [7:0]  hi;
  } lead_t;

  typedef struct packed {
    logic        emit;
    logic [20:0] cp;
    logic        none_yet;
    logic        prev_cr;
  } hand_t;

  // Decode a lead byte: either a finished code point or a pending sequence
  function automatic lead_t lead_dec(input logic [7:0] b);
    lead_t l;
    l.emit = 1'b0;
    l.cp   = CP_REPL;
    l.need = 2'd0;
    l.part = 21'd0;
    l.lo   = CONT_LO;
    l.hi   = CONT_HI;
    if (b inside {[8'h00:8'h7F]}) begin
      l.emit = 1'b1;
      l.cp   = {13'd0, b};
    end else if (b inside {[8'hC2:8'hDF]}) begin
      l.need = 2'd1;
      l.part = {16'd0, b[4:0]};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      l.need = 2'd2;
      l.part = {17'd0, b[3:0]};
      if (b == 8'hE0) l.lo = E0_LO;
      if (b == 8'hED) l.hi = ED_HI;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      l.need = 2'd3;
      l.part = {18'd0, b[2:0]};
      if (b == 8'hF0) l.lo = F0_LO;
      if (b == 8'hF4) l.hi = F4_HI;
    end else begin
      l.emit = 1'b1;
    end
    return l;
  endfunction

  // Preprocess one decoded code point (BOM, CR/LF/FF, NUL)
  function automatic hand_t hand_on(input logic v, input logic [20:0] cp,
                                    input logic none_yet, input logic prev_cr);
    hand_t h;
    h.emit     = 1'b0;
    h.cp       = cp;
    h.none_yet = none_yet;
    h.prev_cr  = prev_cr;
    if (v) begin
      h.none_yet = 1'b0;
      if (none_yet && cp == CP_BOM) begin
        h.emit = 1'b0;
      end else if (cp == CP_CR) begin
        h.emit    = 1'b1;
        h.cp      = CP_LF;
        h.prev_cr = 1'b1;
      end else begin
        h.prev_cr = 1'b0;
        h.emit    = 1'b1;
        if (cp == CP_LF) begin
          h.emit = !prev_cr;
        end else if (cp == CP_FF) begin
          h.cp = CP_LF;
        end else if (cp == CP_NUL) begin
          h.cp = CP_REPL;
        end
      end
    end
    return h;
  endfunction

  // Load decoder fields from a lead byte
  function automatic dec_state_t load_lead(input dec_state_t s, input lead_t l);
    dec_state_t r;
    r         = s;
    r.needed  = l.need;
    r.seen    = 2'd0;
    r.partial = l.part;
    r.lo      = l.lo;
    r.hi      = l.hi;
    return r;
  endfunction

  // Return the decoder fields to idle
  function automatic dec_state_t clear_dec(input dec_state_t s);
    dec_state_t r;
    r         = s;
    r.partial = DEC_RESET.partial;
    r.needed  = DEC_RESET.needed;
    r.seen    = DEC_RESET.seen;
    r.lo      = DEC_RESET.lo;
    r.hi      = DEC_RESET.hi;
    return r;
  endfunction

  lead_t       ld;
  dec_state_t  nx;
  logic        v0, v1;
  logic [20:0] c0, c1;
  logic [20:0] part_sh;
  logic [1:0]  seen_inc;
  hand_t       h0, h1;
  logic [1:0]  cnt;
  logic        marker;
  logic [1:0]  n;
  logic [7:0]  b;

  // Decoder step: up to two code points handed on
  always_comb begin
    b        = src.in_byte;
    ld       = lead_dec(b);
    nx       = st;
    v0       = 1'b0;
    v1       = 1'b0;
    c0       = CP_REPL;
    c1       = CP_REPL;
    part_sh  = {st.partial[14:0], b[5:0]};
    seen_inc = 2'(st.seen + 2'd1);
    if (!st.halted) begin
      if (b == 8'h00) begin
        // NUL ends decoding; a pending sequence is flushed as U+FFFD
        v0        = (st.needed != 2'd0);
        nx        = clear_dec(st);
        nx.halted = 1'b1;
      end else if (st.needed == 2'd0) begin
        v0 = ld.emit;
        c0 = ld.cp;
        nx = load_lead(st, ld);
      end else if (b < st.lo || b > st.hi) begin
        // bad continuation: U+FFFD, then the byte starts afresh
        v0 = 1'b1;
        v1 = ld.emit;
        c1 = ld.cp;
        nx = load_lead(st, ld);
      end else if (seen_inc == st.needed) begin
        v0 = 1'b1;
        c0 = part_sh;
        nx = clear_dec(st);
      end else begin
        nx.partial = part_sh;
        nx.seen    = seen_inc;
        nx.lo      = CONT_LO;
        nx.hi      = CONT_HI;
      end
    end
    // truncated sequence at stream end
    if (src.stream_end && !nx.halted && nx.needed != 2'd0) begin
      if (v0) begin
        v1 = 1'b1;
        c1 = CP_REPL;
      end else begin
        v0 = 1'b1;
        c0 = CP_REPL;
      end
    end
  end

  // Preprocessing of the two candidates in order
  assign h0 = hand_on(v0, c0, st.none_yet, st.prev_cr);
  assign h1 = hand_on(v1, c1, h0.none_yet, h0.prev_cr);

  assign cnt    = {1'b0, h0.emit} + {1'b0, h1.emit};
  assign marker = src.stream_end && (cnt == 2'd0);
  assign n      = marker ? 2'd1 : cnt;

  // Pack results; the first slot takes whichever emitted first
  always_comb begin
    res.n                 = n;
    res.r0.code_point     = marker ? 21'd0 : (h0.emit ? h0.cp : h1.cp);
    res.r0.has_code       = !marker;
    res.r0.run_last       = (n == 2'd1);
    res.r0.end_of_text    = src.stream_end && (n == 2'd1);
    res.r1.code_point     = h1.cp;
    res.r1.has_code       = 1'b1;
    res.r1.run_last       = 1'b1;
    res.r1.end_of_text    = src.stream_end;
  end

  // Next state; stream end returns everything to reset
  always_comb begin
    st_next          = nx;
    st_next.none_yet = h1.none_yet;
    st_next.prev_cr  = h1.prev_cr;
    if (src.stream_end) begin
      st_next = DEC_RESET;
    end
  end

endmodule

@@ rtl/ucss_outbuf.sv @@
// Two-entry result buffer that hands results out one word per cycle while res_stall is low.
// Depends on ucss_pkg.
module ucss_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ucss_pkg::res_set_t  res,
  output logic                can_load,
  output logic                res_valid,
  input  logic                res_stall,
  output ucss_pkg::res_t      res_data
);
  import ucss_pkg::*;

  logic [1:0] cnt;
  res_t       e0, e1;
  logic       take;

  assign res_valid = (cnt != 2'd0);
  assign res_data  = e0;
  assign take      = res_valid && !res_stall;
  // empty, or emptied by this cycle's transfer
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && take);

  // Occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.n;
    end else if (take) begin
      cnt <= 2'(cnt - 2'd1);
    end
  end

  // Entries; the second moves up once the first is taken
  always_ff @(posedge clk) begin
    if (load) begin
      e0 <= res.r0;
      e1 <= res.r1;
    end else if (take) begin
      e0 <= e1;
    end
  end

endmodule

@@ rtl/ucss_checker.sv @@
// Port-level checks for the UTF-8 decoder with CSS preprocessing, and its bind.
// Depends on ucss_pkg and utf8_decoder_css_preprocess.
module ucss_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input ucss_pkg::res_t res_data
);
  import ucss_pkg::*;

  // A stalled output word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("output word changed while stalled");

  // End marker is only ever the single, final word of a stream
  a_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.has_code |->
      res_data.end_of_text && res_data.run_last && res_data.code_point == 21'd0)
    else $error("malformed end marker");

  // End of text always closes the byte's run
  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.end_of_text |-> res_data.run_last)
    else $error("end_of_text without run_last");

  // Preprocessing leaves no CR, FF or NUL, and values stay in range
  a_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.has_code |->
      res_data.code_point != CP_CR && res_data.code_point != CP_FF &&
      res_data.code_point != CP_NUL && res_data.code_point <= 21'h10FFFF)
    else $error("unprocessed or out-of-range code point");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("output valid after reset");

endmodule

bind utf8_decoder_css_preprocess ucss_checker u_ucss_checker (.*);

@@ tb/sv/ucss_check.sv @@
// Checker for the UTF-8 decoder with CSS preprocessing: watches both channels,
// predicts the code point words from each accepted byte and compares them.
// Depends on ucss_pkg.
`timescale 1ns / 1ps

module ucss_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  input  logic           src_stall,
  input  ucss_pkg::src_t src_data,
  input  logic           res_valid,
  input  logic           res_stall,
  input  ucss_pkg::res_t res_data,
  output int             n_err,
  output int             n_due
);
  import ucss_pkg::*;

  // Lead byte ranges
  localparam logic [7:0] ASCII_TOP = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] BYTE_NUL  = CP_NUL[7:0];

  dec_state_t  dec;            // decoder and preprocessing state
  logic [20:0] byte_cps [2];   // code points caused by the current byte
  int          byte_cp_n;
  res_t        cps_due [$];    // words still to come, oldest first
  res_t        want;
  int          fail_cnt = 0;

  function automatic void note_cp(input logic [20:0] cp);
    if (byte_cp_n < 2) begin
      byte_cps[byte_cp_n] = cp;
      byte_cp_n++;
    end
  endfunction

  // CSS preprocessing of one decoded code point
  function automatic void css_filter(input logic [20:0] cp);
    if (dec.none_yet && cp == CP_BOM) begin
      dec.none_yet = 1'b0;
      return;
    end
    dec.none_yet = 1'b0;
    if (cp == CP_CR) begin
      note_cp(CP_LF);
      dec.prev_cr = 1'b1;
      return;
    end
    if (cp == CP_LF) begin
      if (!dec.prev_cr) note_cp(CP_LF);
    end else if (cp == CP_FF) begin
      note_cp(CP_LF);
    end else if (cp == CP_NUL) begin
      note_cp(CP_REPL);
    end else begin
      note_cp(cp);
    end
    dec.prev_cr = 1'b0;
  endfunction

  function automatic void drop_seq();
    dec.partial = '0;
    dec.needed  = '0;
    dec.seen    = '0;
    dec.lo      = CONT_LO;
    dec.hi      = CONT_HI;
  endfunction

  function automatic void start_seq(input logic [7:0] b);
    if (b <= ASCII_TOP) begin
      css_filter({13'd0, b});
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      dec.needed  = 2'd1;
      dec.partial = {16'd0, b[4:0]};
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      if (b == LEAD_E0) dec.lo = E0_LO;
      else if (b == LEAD_ED) dec.hi = ED_HI;
      dec.needed  = 2'd2;
      dec.partial = {17'd0, b[3:0]};
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      if (b == LEAD4_LO) dec.lo = F0_LO;
      else if (b == LEAD4_HI) dec.hi = F4_HI;
      dec.needed  = 2'd3;
      dec.partial = {18'd0, b[2:0]};
    end else begin
      css_filter(CP_REPL);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [20:0] cp;
    if (dec.needed == 2'd0) begin
      start_seq(b);
      return;
    end
    // out-of-bounds continuation: replacement, then the byte starts afresh
    if (b < dec.lo || b > dec.hi) begin
      drop_seq();
      css_filter(CP_REPL);
      start_seq(b);
      return;
    end
    dec.lo      = CONT_LO;
    dec.hi      = CONT_HI;
    dec.partial = {dec.partial[14:0], b[5:0]};
    dec.seen    = dec.seen + 2'd1;
    if (dec.seen == dec.needed) begin
      cp = dec.partial;
      drop_seq();
      css_filter(cp);
    end
  endfunction

  // Expected words for one accepted byte
  function automatic void predict_cps(input src_t w);
    res_t r;
    logic marker;
    marker    = 1'b0;
    byte_cp_n = 0;
    if (!dec.halted) begin
      if (w.in_byte == BYTE_NUL) begin
        if (dec.needed != 2'd0) css_filter(CP_REPL);
        drop_seq();
        dec.halted = 1'b1;
      end else begin
        decode_byte(w.in_byte);
      end
    end
    if (w.stream_end) begin
      if (!dec.halted && dec.needed != 2'd0) css_filter(CP_REPL);
      if (byte_cp_n == 0) begin
        marker      = 1'b1;
        byte_cps[0] = '0;
        byte_cp_n   = 1;
      end
      drop_seq();
      dec.prev_cr  = 1'b0;
      dec.none_yet = 1'b1;
      dec.halted   = 1'b0;
    end
    for (int k = 0; k < byte_cp_n; k++) begin
      r.code_point  = byte_cps[k];
      r.has_code    = !marker;
      r.end_of_text = w.stream_end && (k == byte_cp_n - 1);
      r.run_last    = (k == byte_cp_n - 1);
      cps_due.insert(cps_due.size(), r);
    end
  endfunction

  function automatic void flag_field(input string fld, input logic [20:0] exp_v,
                                     input logic [20:0] got_v);
    $error("%s: expected %0h, got %0h", fld, exp_v, got_v);
    fail_cnt++;
  endfunction

  // Predict on accepted bytes, compare accepted words
  always @(posedge clk) begin
    if (rst) begin
      dec = DEC_RESET;
      cps_due.delete();
    end else begin
      if (src_valid && !src_stall) predict_cps(src_data);
      if (res_valid && !res_stall) begin
        if (cps_due.size() == 0) begin
          flag_field("unexpected word, code_point", '0, res_data.code_point);
        end else begin
          want = cps_due.pop_front();
          if (res_data.code_point !== want.code_point)
            flag_field("code_point", want.code_point, res_data.code_point);
          if (res_data.has_code !== want.has_code)
            flag_field("has_code", 21'(want.has_code), 21'(res_data.has_code));
          if (res_data.end_of_text !== want.end_of_text)
            flag_field("end_of_text", 21'(want.end_of_text),
                       21'(res_data.end_of_text));
          if (res_data.run_last !== want.run_last)
            flag_field("run_last", 21'(want.run_last), 21'(res_data.run_last));
        end
      end
    end
    n_due <= cps_due.size();
    n_err <= fail_cnt;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for utf8_decoder_css_preprocess: drives byte streams with
// idling and back-pressure, and gives the verdict from ucss_check.
// Depends on ucss_pkg, ucss_check and the RTL.
`timescale 1ns / 1ps

module tb;
  import ucss_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic src_valid = 1'b0;
  src_t src_data  = '0;
  logic res_stall = 1'b0;
  logic src_stall;
  logic res_valid;
  res_t res_data;

  int   n_err;
  int   n_due;
  int   src_idle_pct  = 0;
  int   res_stall_pct = 0;
  logic hold_req      = 1'b0;
  int   hold_cnt      = 0;
  int   bytes_sent    = 0;
  logic [7:0] stream_bytes [$];

  utf8_decoder_css_preprocess DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  ucss_check u_check (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .n_err     (n_err),
    .n_due     (n_due)
  );

  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      res_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      res_stall <= ($urandom_range(99) < res_stall_pct);
    end
  end

  task automatic set_idling(input int src_pct, input int res_pct);
    src_idle_pct = src_pct;
    res_stall_pct <= res_pct;
  endtask

  task automatic send_word(input src_t w);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    src_valid <= 1'b1;
    src_data  <= w;
    do @(posedge clk); while (src_stall);
  endtask

  // Appends one byte to the stream being built
  function automatic void add_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  // Sends the queued bytes as one stream
  task automatic send_stream();
    src_t w;
    if (stream_bytes.size() == 0) add_byte(8'($urandom_range(1, 255)));
    foreach (stream_bytes[i]) begin
      w.in_byte    = stream_bytes[i];
      w.stream_end = (i == stream_bytes.size() - 1);
      bytes_sent++;
      send_word(w);
    end
  endtask

  // Sender pauses until every expected word is out
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
  endtask

  function automatic void put_utf8(input logic [20:0] c);
    if (c < 21'h80) begin
      add_byte(c[7:0]);
    end else if (c < 21'h800) begin
      add_byte({3'b110, c[10:6]});
      add_byte({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      add_byte({4'b1110, c[15:12]});
      add_byte({2'b10, c[11:6]});
      add_byte({2'b10, c[5:0]});
    end else begin
      add_byte({5'b11110, c[20:18]});
      add_byte({2'b10, c[17:12]});
      add_byte({2'b10, c[11:6]});
      add_byte({2'b10, c[5:0]});
    end
  endfunction

  // One random stream: mostly well-formed text, some broken sequences
  task automatic build_stream();
    int          units;
    int          pick;
    logic [20:0] cp;
    stream_bytes.delete();
    units = $urandom_range(0, 8);
    if ($urandom_range(3) == 0) put_utf8(CP_BOM);
    repeat (units) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        add_byte(8'($urandom_range(1, 127)));
      end else if (pick < 30) begin
        put_utf8(pick < 24 ? CP_CR : (pick < 28 ? CP_LF : CP_FF));
      end else if (pick < 42) begin
        put_utf8(21'($urandom_range(12'h080, 12'h7FF)));
      end else if (pick < 56) begin
        case ($urandom_range(7))
          0: cp = 21'h000800;
          1: cp = 21'h00D7FF;
          2: cp = 21'h00E000;
          3: cp = 21'h00FFFF;
          4: cp = CP_BOM;
          default: begin
            cp = 21'($urandom_range(16'h0800, 16'hFFFF));
            if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h001000;
          end
        endcase
        put_utf8(cp);
      end else if (pick < 68) begin
        case ($urandom_range(3))
          0: cp = 21'h010000;
          1: cp = 21'h10FFFF;
          default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
        endcase
        put_utf8(cp);
      end else if (pick < 90) begin
        // broken sequences
        case ($urandom_range(7))
          0: add_byte(8'($urandom_range(8'h80, 8'hBF)));
          1: begin
            if ($urandom_range(1)) add_byte(8'($urandom_range(8'hC0, 8'hC1)));
            else add_byte(8'($urandom_range(8'hF5, 8'hFF)));
          end
          2: begin
            add_byte(8'hE0);
            add_byte(8'($urandom_range(8'h80, 8'h9F)));
          end
          3: begin
            add_byte(8'hED);
            add_byte(8'($urandom_range(8'hA0, 8'hBF)));
          end
          4: begin
            add_byte(8'hF0);
            add_byte(8'($urandom_range(8'h80, 8'h8F)));
          end
          5: begin
            add_byte(8'hF4);
            add_byte(8'($urandom_range(8'h90, 8'hBF)));
          end
          6: begin
            // short sequence: a lead with at most one continuation, often left truncated
            add_byte(8'($urandom_range(8'hC2, 8'hF4)));
            if ($urandom_range(1)) add_byte(8'($urandom_range(8'h90, 8'h9F)));
          end
          default: add_byte(8'($urandom_range(1, 255)));
        endcase
      end else if (pick < 93) begin
        add_byte(CP_NUL[7:0]);
      end else begin
        add_byte(8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: leading and later BOM, CR/LF/FF handling, pending at end
    stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h0D, 8'h0A, 8'h0C,
                     8'hEF, 8'hBB, 8'hBF, 8'h7F, 8'hF0, 8'h9F};
    send_stream();
    // Directed: bounds per lead, re-decoded byte, max code point, zero byte
    stream_bytes = '{8'hC2, 8'h80, 8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE2, 8'h00, 8'h41};
    send_stream();
    drain();

    // Random streams under each idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(49, 0);
        2: set_idling(0, 49);
        3: set_idling(12, 12);
        4: begin
          set_idling(0, 0);
          hold_req <= 1'b1;
        end
        default: set_idling(0, 0);
      endcase
      target = bytes_sent + ((ph == 4) ? 60 : 128);
      while (bytes_sent < target) begin
        build_stream();
        send_stream();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (n_err == 0 && n_due == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ utf8_decoder_css_preprocess.f @@
rtl/ucss_pkg.sv
rtl/ucss_decode.sv
rtl/ucss_outbuf.sv
rtl/utf8_decoder_css_preprocess.sv
rtl/ucss_checker.sv
tb/sv/ucss_check.sv
tb/sv/tb.sv
